### design/evas_pkg.sv
// ----------------------------------------------------------------------------
// evas_pkg
// Types, register indexes and constants for the energy voice activity
// segmenter.
// ----------------------------------------------------------------------------
package evas_pkg;

  localparam int DEF_MAX_CHUNK_SAMPLES   = 4096;
  localparam int DEF_SEGMENT_LENGTH_BITS = 24;

  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 16;
  localparam int RUN_W      = 10;
  localparam int MIN_W      = 10;
  localparam int SUM_W      = 28;
  localparam int OUT_LEN_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENT_CHUNKS_TO_STOP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENT_CHUNKS    = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd750;
  localparam logic [RUN_W-1:0] STOP_RESET      = 10'd30;
  localparam logic [MIN_W-1:0] MIN_RESET       = 10'd50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       chunk_last;
  } in_t;

  typedef struct packed {
    logic                 chunk_voiced;
    logic                 chunk_kept;
    logic                 segment_end;
    logic [OUT_LEN_W-1:0] segment_samples;
    logic [RUN_W-1:0]     silent_run;
  } out_t;

endpackage

### design/energy_voice_activity_segmenter.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_segmenter
// Chunk energy detector with silence-terminated segment tracking.
// ----------------------------------------------------------------------------
// Takes one PCM sample per cycle and gives one result word per closed chunk.
// A sample is held in an input register; from there its magnitude is added
// to the chunk sum and, when it closes the chunk, the voiced decision and
// the segment update are made and the result register is loaded, so the
// result word is registered. The sustained rate is one
// sample per cycle; in_stall rises only while a chunk-closing sample waits
// behind a result word that the receiver stalls. A chunk also closes by
// itself when it reaches MAX_CHUNK_SAMPLES samples.
module energy_voice_activity_segmenter #(
  parameter int MAX_CHUNK_SAMPLES   = evas_pkg::DEF_MAX_CHUNK_SAMPLES,
  parameter int SEGMENT_LENGTH_BITS = evas_pkg::DEF_SEGMENT_LENGTH_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [evas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evas_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  evas_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output evas_pkg::out_t                  out_data
);

  localparam int CW    = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int SLW   = SEGMENT_LENGTH_BITS;
  localparam int PW    = evas_pkg::THR_W + 1 + CW;
  localparam int NW    = PW + 1;
  localparam int CMPW  = (NW > evas_pkg::SUM_W) ? NW : evas_pkg::SUM_W;
  localparam int SUMW  = ((SLW > CW) ? SLW : CW) + 1;
  localparam int MW    = evas_pkg::MIN_W + CW;
  localparam int LCMPW = (SLW > MW) ? SLW : MW;
  localparam int LW    = (SLW > evas_pkg::OUT_LEN_W) ? SLW : evas_pkg::OUT_LEN_W;
  localparam int RUN_W = evas_pkg::RUN_W;

  logic [evas_pkg::THR_W-1:0] silence_threshold;
  logic [RUN_W-1:0]           silent_chunks_to_stop;
  logic [evas_pkg::MIN_W-1:0] min_segment_chunks;

  logic          s1_valid;
  evas_pkg::in_t s1_data;

  logic                       in_segment;
  logic [evas_pkg::SUM_W-1:0] level_sum;
  logic [CW-1:0]              chunk_samples;
  logic [SLW-1:0]             segment_length;
  logic [RUN_W-1:0]           silence_run;

  logic [evas_pkg::SUM_W-1:0] level_sum_next;
  logic [CW-1:0]              chunk_samples_next;
  logic                       in_segment_next;
  logic [SLW-1:0]             segment_length_next;
  logic [RUN_W-1:0]           silence_run_next;

  logic [evas_pkg::SAMPLE_W:0] mag;
  logic [evas_pkg::SUM_W:0]    sum_add;
  logic [evas_pkg::SUM_W-1:0]  sum_sat;
  logic [CW-1:0]               n;
  logic                        closes;
  logic [PW-1:0]               prod;
  logic [NW-1:0]               need;
  logic                        voiced;
  logic                        open_seg;
  logic [SUMW-1:0]             len_add;
  logic [SLW-1:0]              len_sat;
  logic [MW-1:0]               min_len;
  logic [RUN_W-1:0]            run_upd;
  logic                        ended;
  logic [LW-1:0]               len_ext;
  logic                        out_free;
  logic                        proceed;
  evas_pkg::out_t              result;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_threshold     <= evas_pkg::THRESHOLD_RESET;
      silent_chunks_to_stop <= evas_pkg::STOP_RESET;
      min_segment_chunks    <= evas_pkg::MIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        evas_pkg::REG_SILENCE_THRESHOLD:
          silence_threshold <= cfg_data;
        evas_pkg::REG_SILENT_CHUNKS_TO_STOP:
          silent_chunks_to_stop <= cfg_data[RUN_W-1:0];
        evas_pkg::REG_MIN_SEGMENT_CHUNKS:
          min_segment_chunks <= cfg_data[evas_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign proceed  = s1_valid && (!closes || out_free);
  assign in_stall = s1_valid && !proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    mag     = s1_data.sample[evas_pkg::SAMPLE_W-1]
              ? (evas_pkg::SAMPLE_W + 1)'(-{s1_data.sample[evas_pkg::SAMPLE_W-1],
                                            s1_data.sample})
              : {1'b0, s1_data.sample};
    sum_add = (evas_pkg::SUM_W + 1)'(level_sum) + (evas_pkg::SUM_W + 1)'(mag);
    sum_sat = sum_add[evas_pkg::SUM_W] ? '1 : sum_add[evas_pkg::SUM_W-1:0];
    n       = chunk_samples + CW'(1);
    closes  = s1_data.chunk_last || (n >= CW'(MAX_CHUNK_SAMPLES));

    prod    = PW'({1'b0, silence_threshold} + 17'd1) * PW'(n);
    need    = {prod, 1'b0};
    voiced  = CMPW'(sum_sat) >= CMPW'(need);

    open_seg = in_segment || voiced;
    len_add  = SUMW'(segment_length) + SUMW'(n);
    len_sat  = (len_add > SUMW'({SLW{1'b1}})) ? '1 : SLW'(len_add);
    min_len  = MW'(min_segment_chunks) * MW'(n);
    if (voiced) begin
      run_upd = '0;
    end else if (in_segment) begin
      run_upd = (silence_run == '1) ? silence_run : silence_run + RUN_W'(1);
    end else begin
      run_upd = RUN_W'(1);
    end
    ended = open_seg && !voiced && (run_upd >= silent_chunks_to_stop)
            && (LCMPW'(len_sat) >= LCMPW'(min_len));

    len_ext = LW'(len_sat);
    result.chunk_voiced    = voiced;
    result.chunk_kept      = open_seg;
    result.segment_end     = ended;
    result.segment_samples = !open_seg ? '0
                           : (len_ext > LW'({evas_pkg::OUT_LEN_W{1'b1}})) ? '1
                           : len_ext[evas_pkg::OUT_LEN_W-1:0];
    result.silent_run      = open_seg ? run_upd : '0;

    level_sum_next      = closes ? '0 : sum_sat;
    chunk_samples_next  = closes ? '0 : n;
    in_segment_next     = in_segment;
    segment_length_next = segment_length;
    silence_run_next    = silence_run;
    if (closes && open_seg) begin
      in_segment_next     = !ended;
      segment_length_next = ended ? '0 : len_sat;
      silence_run_next    = ended ? '0 : run_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_segment     <= 1'b0;
      level_sum      <= '0;
      chunk_samples  <= '0;
      segment_length <= '0;
      silence_run    <= '0;
    end else if (proceed) begin
      in_segment     <= in_segment_next;
      level_sum      <= level_sum_next;
      chunk_samples  <= chunk_samples_next;
      segment_length <= segment_length_next;
      silence_run    <= silence_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && closes) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && closes) begin
      out_data <= result;
    end
  end

endmodule

### design/evas_check.sv
// ----------------------------------------------------------------------------
// evas_check
// Port-level checks for the energy voice activity segmenter.
// ----------------------------------------------------------------------------
module evas_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_write,
  input logic [evas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [evas_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                            in_valid,
  input logic                            in_stall,
  input evas_pkg::in_t                   in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input evas_pkg::out_t                  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_end_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.segment_end |-> out_data.chunk_kept && !out_data.chunk_voiced)
    else $error("segment end on a chunk that was not kept or was voiced");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.chunk_kept |->
      out_data.segment_samples == '0 && out_data.silent_run == '0)
    else $error("length or run reported outside a segment");

  a_voiced_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.chunk_voiced |-> out_data.chunk_kept && out_data.silent_run == '0)
    else $error("voiced chunk not kept or left a silent run");

endmodule

bind energy_voice_activity_segmenter evas_check u_evas_check (.*);

### tb/energy_voice_activity_segmenter_tb.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_segmenter_tb
// Drives PCM sample words through the segmenter and checks every chunk result
// word against a cycle-free model of the chunk energy and segment logic. A
// short scripted sequence covers field extremes, threshold boundaries and
// zero stop and minimum settings. It is followed by random rounds under
// changing register settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module energy_voice_activity_segmenter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_CHUNK    = evas_pkg::DEF_MAX_CHUNK_SAMPLES;
  localparam longint LEN_CAP      = (64'd1 << evas_pkg::DEF_SEGMENT_LENGTH_BITS) - 1;
  localparam longint SUM_CAP      = (64'd1 << evas_pkg::SUM_W) - 1;
  localparam longint OUT_CAP      = (64'd1 << evas_pkg::OUT_LEN_W) - 1;
  localparam int     RUN_CAP      = (1 << evas_pkg::RUN_W) - 1;
  localparam int     IN_W         = $bits(evas_pkg::in_t);
  localparam int     DRAIN_CYCLES = 8;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     ROUND_WORDS  = 100;
  localparam int     NUM_ROUNDS   = 8;
  localparam int     REPORT_MAX   = 10;

  localparam logic [evas_pkg::CFG_IDX_W-1:0] REG_THR  = evas_pkg::REG_SILENCE_THRESHOLD;
  localparam logic [evas_pkg::CFG_IDX_W-1:0] REG_STOP = evas_pkg::REG_SILENT_CHUNKS_TO_STOP;
  localparam logic [evas_pkg::CFG_IDX_W-1:0] REG_MIN  = evas_pkg::REG_MIN_SEGMENT_CHUNKS;

  typedef enum logic [1:0] {ROW_WORD, ROW_TYPED, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic [evas_pkg::SAMPLE_W-1:0]      val;
    logic                               last;
    logic [evas_pkg::CFG_IDX_W-1:0]     idx;
    evas_pkg::out_t                     want;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [evas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [evas_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  evas_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  evas_pkg::out_t                  out_data;

  int             idle_pct = 0;
  int             stall_pct = 0;
  int             cycles = 0;
  int             failures = 0;
  int             words_sent = 0;
  evas_pkg::out_t pending_results[$];
  evas_pkg::out_t head;
  row_t           script [21];

  bit     in_seg;
  longint chunk_sum;
  int     chunk_count;
  longint seg_len;
  int     seg_run;
  int     cfg_thr;
  int     cfg_stop;
  int     cfg_min;

  energy_voice_activity_segmenter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic bit segment_predict(input evas_pkg::in_t w, output evas_pkg::out_t r);
    int     s;
    longint mag;
    longint n;
    longint need;
    longint shown;
    bit     close;
    bit     voiced;
    bit     ended;
    s = $signed(w.sample);
    mag = (s < 0) ? -s : s;
    r = '0;
    chunk_sum += mag;
    if (chunk_sum > SUM_CAP) chunk_sum = SUM_CAP;
    chunk_count++;
    close = w.chunk_last;
    if (chunk_count >= MAX_CHUNK) begin
      chunk_count = MAX_CHUNK;
      close = 1'b1;
    end
    if (!close) return 1'b0;
    n = chunk_count;
    need = (longint'(cfg_thr) + 1) * 2 * n;
    voiced = chunk_sum >= need;
    chunk_sum = 0;
    chunk_count = 0;
    ended = 1'b0;
    if (!in_seg && voiced) begin
      in_seg = 1'b1;
      seg_run = 0;
    end
    if (in_seg) begin
      seg_len += n;
      if (seg_len > LEN_CAP) seg_len = LEN_CAP;
      if (!voiced) begin
        if (seg_run < RUN_CAP) seg_run++;
        if (seg_run >= cfg_stop && seg_len >= longint'(cfg_min) * n) ended = 1'b1;
      end else begin
        seg_run = 0;
      end
      shown = (seg_len > OUT_CAP) ? OUT_CAP : seg_len;
      r.chunk_kept = 1'b1;
      r.segment_samples = shown[evas_pkg::OUT_LEN_W-1:0];
      r.silent_run = seg_run[evas_pkg::RUN_W-1:0];
      if (ended) begin
        in_seg = 1'b0;
        seg_run = 0;
        seg_len = 0;
      end
    end
    r.chunk_voiced = voiced;
    r.segment_end = ended;
    return 1'b1;
  endfunction

  function automatic logic [evas_pkg::SAMPLE_W-1:0] make_sample(input int mag, input bit neg);
    logic [evas_pkg::SAMPLE_W-1:0] v;
    if (mag >= 32768) return 16'h8000;
    v = mag[evas_pkg::SAMPLE_W-1:0];
    return neg ? -v : v;
  endfunction

  task automatic set_pressure(input int phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 54; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 54; end
      default: begin idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  task automatic send_word(input evas_pkg::in_t w, input bit typed_on,
                           input evas_pkg::out_t typed);
    evas_pkg::out_t r;
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (segment_predict(w, r)) pending_results.push_back(typed_on ? typed : r);
    words_sent++;
    @(negedge clk);
  endtask

  // drop valid, drain all results, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [evas_pkg::CFG_IDX_W-1:0] idx,
                           input logic [evas_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_THR:  cfg_thr = int'(val[evas_pkg::THR_W-1:0]);
      REG_STOP: cfg_stop = int'(val[evas_pkg::RUN_W-1:0]);
      REG_MIN:  cfg_min = int'(val[evas_pkg::MIN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_chunk(input int len, input bit loud, input bit hold_last);
    int            target;
    int            lo;
    int            hi;
    evas_pkg::in_t w;
    target = 2 * (cfg_thr + 1);
    if (loud) begin
      lo = (target > 32768) ? 32768 : target;
      hi = (2 * target > 32768) ? 32768 : 2 * target;
    end else begin
      lo = 0;
      hi = (target - 1 > 32768) ? 32768 : target - 1;
    end
    for (int i = 0; i < len; i++) begin
      w.sample = make_sample($urandom_range(hi, lo), 1'($urandom_range(1, 0)));
      w.chunk_last = (i == len - 1) && !hold_last;
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected result word: v%0d k%0d e%0d len %0d run %0d",
                   out_data.chunk_voiced, out_data.chunk_kept, out_data.segment_end,
                   out_data.segment_samples, out_data.silent_run);
      end else begin
        head = pending_results.pop_front();
        if (out_data.chunk_voiced !== head.chunk_voiced ||
            out_data.chunk_kept !== head.chunk_kept ||
            out_data.segment_end !== head.segment_end ||
            out_data.segment_samples !== head.segment_samples ||
            out_data.silent_run !== head.silent_run) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("result mismatch: expected v%0d k%0d e%0d len %0d run %0d, %s",
                     head.chunk_voiced, head.chunk_kept, head.segment_end,
                     head.segment_samples, head.silent_run,
                     $sformatf("got v%0d k%0d e%0d len %0d run %0d",
                               out_data.chunk_voiced, out_data.chunk_kept,
                               out_data.segment_end, out_data.segment_samples,
                               out_data.silent_run));
        end
      end
    end
  end

  initial begin
    int             start;
    int             pick;
    int             mag;
    int             thr_val;
    evas_pkg::out_t none;
    none = '0;
    script = '{
      '{ROW_TYPED, 16'h7FFF, 1'b1, REG_THR,  '{1'b1, 1'b1, 1'b0, 24'd1, 10'd0}},
      '{ROW_WORD,  16'h8000, 1'b0, REG_THR,  '0},
      '{ROW_TYPED, 16'h0000, 1'b1, REG_THR,  '{1'b1, 1'b1, 1'b0, 24'd3, 10'd0}},
      '{ROW_TYPED, 16'h0000, 1'b1, REG_THR,  '{1'b0, 1'b1, 1'b0, 24'd4, 10'd1}},
      '{ROW_WORD,  16'h0001, 1'b0, REG_THR,  '0},
      '{ROW_WORD,  16'hFFFF, 1'b1, REG_THR,  '0},
      '{ROW_WORD,  16'd1502, 1'b1, REG_THR,  '0},
      '{ROW_WORD,  16'hFA23, 1'b1, REG_THR,  '0},
      '{ROW_REG,   16'd0,    1'b0, REG_STOP, '0},
      '{ROW_REG,   16'd0,    1'b0, REG_MIN,  '0},
      '{ROW_WORD,  16'h0000, 1'b1, REG_THR,  '0},
      '{ROW_TYPED, 16'h0000, 1'b1, REG_THR,  '0},
      '{ROW_REG,   16'd0,    1'b0, REG_THR,  '0},
      '{ROW_TYPED, 16'h0001, 1'b1, REG_THR,  '0},
      '{ROW_WORD,  16'h0002, 1'b1, REG_THR,  '0},
      '{ROW_WORD,  16'h0000, 1'b1, REG_THR,  '0},
      '{ROW_REG,   16'h8000, 1'b0, REG_THR,  '0},
      '{ROW_TYPED, 16'h8000, 1'b1, REG_THR,  '0},
      '{ROW_REG,   16'd1023, 1'b0, REG_STOP, '0},
      '{ROW_REG,   16'd1023, 1'b0, REG_MIN,  '0},
      '{ROW_REG,   16'd750,  1'b0, REG_THR,  '0}
    };
    in_seg = 1'b0;
    chunk_sum = 0;
    chunk_count = 0;
    seg_len = 0;
    seg_run = 0;
    cfg_thr = int'(evas_pkg::THRESHOLD_RESET);
    cfg_stop = int'(evas_pkg::STOP_RESET);
    cfg_min = int'(evas_pkg::MIN_RESET);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_pressure(0);
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG)
        write_reg(script[i].idx, script[i].val);
      else
        send_word(evas_pkg::in_t'({script[i].val, script[i].last}),
                  script[i].kind == ROW_TYPED, script[i].want);
    end

    for (int round = 0; round < NUM_ROUNDS; round++) begin
      case (round)
        0: thr_val = 0;
        3: thr_val = 16383;
        default: thr_val = $urandom_range(2000, 0);
      endcase
      write_reg(REG_THR, thr_val[evas_pkg::CFG_DATA_W-1:0]);
      write_reg(REG_STOP, (round == 6) ? 16'd1023 : 16'($urandom_range(6, 0)));
      write_reg(REG_MIN, (round == 6) ? 16'd1023 : 16'($urandom_range(8, 0)));
      set_pressure(round);
      start = words_sent;
      while (words_sent - start < ROUND_WORDS) begin
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
          mag = 2 * (cfg_thr + 1) - $urandom_range(1, 0);
          if (mag > 32768) mag = 32768;
          send_word(evas_pkg::in_t'({make_sample(mag, 1'($urandom_range(1, 0))), 1'b1}),
                    1'b0, none);
        end else if (pick < 10) begin
          send_word(evas_pkg::in_t'(IN_W'($urandom)), 1'b0, none);
        end else begin
          send_chunk((pick < 85) ? $urandom_range(6, 1) : $urandom_range(40, 7),
                     $urandom_range(99, 0) < 45, 1'b0);
        end
      end
    end

    settle();
    if (failures == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
